[rtl/ohlc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ohlc_pkg
// Shared types and constants of the OHLC bar resampler.
// ----------------------------------------------------------------------------
package ohlc_pkg;

  localparam int DEF_PRICE_BITS  = 32;
  localparam int DEF_VOLUME_BITS = 48;

  localparam int TIME_W  = 32;
  localparam int PRICE_W = 32;
  localparam int VOL_W   = 32;
  localparam int OTIME_W = 64;
  localparam int OVOL_W  = 48;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_START  = CFG_IDX_W'(1);
  localparam logic [TIME_W-1:0]    PERIOD_RESET = TIME_W'(60);

  localparam int MQ_DEPTH = 2;
  localparam int OQ_DEPTH = 4;

  // classified bar handed from the front to the back
  typedef struct packed {
    logic [TIME_W-1:0]  idx;
    logic [OTIME_W-1:0] btime;
    logic [PRICE_W-1:0] open_p;
    logic [PRICE_W-1:0] high_p;
    logic [PRICE_W-1:0] low_p;
    logic [PRICE_W-1:0] close_p;
    logic [VOL_W-1:0]   vol;
    logic               valid;
    logic               eos;
  } item_t;

  typedef struct packed {
    logic [OTIME_W-1:0] time_v;
    logic [PRICE_W-1:0] open_p;
    logic [PRICE_W-1:0] high_p;
    logic [PRICE_W-1:0] low_p;
    logic [PRICE_W-1:0] close_p;
    logic [OVOL_W-1:0]  vol;
    logic               has_data;
    logic               last;
  } result_t;

endpackage
`default_nettype wire

[rtl/ohlc_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ohlc_front
// Accepts input bars, finds the bucket index with a bit-serial divider and
// stamps the bucket start time.
// ----------------------------------------------------------------------------
module ohlc_front import ohlc_pkg::*; #(
  parameter int PRICE_BITS = DEF_PRICE_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [TIME_W-1:0]  bar_time,
  input  wire logic [PRICE_W-1:0] open_price,
  input  wire logic [PRICE_W-1:0] high_price,
  input  wire logic [PRICE_W-1:0] low_price,
  input  wire logic [PRICE_W-1:0] close_price,
  input  wire logic [VOL_W-1:0]   volume,
  input  wire logic               end_of_series,
  input  wire logic [TIME_W-1:0]  period_eff,
  input  wire logic [TIME_W-1:0]  start_time,
  output logic                    item_push,
  input  wire logic               item_full,
  output item_t                   item
);

  localparam logic [PRICE_W-1:0] PMASK = (PRICE_BITS >= PRICE_W) ? {PRICE_W{1'b1}} :
                                         PRICE_W'((65'd1 << PRICE_BITS) - 65'd1);
  localparam int CNT_W = $clog2(TIME_W);

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} fstate_t;

  fstate_t             state;
  logic [CNT_W-1:0]    cnt;
  logic [TIME_W-1:0]   diff;
  logic [TIME_W-1:0]   dvd;
  logic [TIME_W-1:0]   rem;
  logic [TIME_W:0]     shifted;
  logic                ge;
  logic [TIME_W-1:0]   rem_next;
  item_t               hold;
  logic [PRICE_W-1:0]  op_m, hi_m, lo_m, cl_m;

  assign op_m = open_price & PMASK;
  assign hi_m = high_price & PMASK;
  assign lo_m = low_price & PMASK;
  assign cl_m = close_price & PMASK;

  // one quotient bit a cycle
  assign shifted  = {rem, dvd[TIME_W-1]};
  assign ge       = shifted >= {1'b0, period_eff};
  assign rem_next = ge ? TIME_W'(shifted - {1'b0, period_eff}) : shifted[TIME_W-1:0];

  assign full      = (state != F_IDLE);
  assign item_push = (state == F_PUSH) && !item_full;

  // idx and btime come from the divider registers
  always_comb begin
    item       = hold;
    item.idx   = dvd;
    item.btime = OTIME_W'(diff - rem) + OTIME_W'(start_time);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (push) begin
            diff         <= bar_time - start_time;
            dvd          <= bar_time - start_time;
            rem          <= '0;
            cnt          <= CNT_W'(TIME_W - 1);
            hold.idx     <= '0;
            hold.btime   <= '0;
            hold.open_p  <= op_m;
            hold.high_p  <= hi_m;
            hold.low_p   <= lo_m;
            hold.close_p <= cl_m;
            hold.vol     <= volume;
            hold.valid   <= (op_m != '0) && (hi_m != '0) && (lo_m != '0) && (cl_m != '0);
            hold.eos     <= end_of_series;
            state        <= F_DIV;
          end
        end
        F_DIV: begin
          rem <= rem_next;
          dvd <= {dvd[TIME_W-2:0], ge};
          cnt <= cnt - CNT_W'(1);
          if (cnt == '0) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!item_full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_rem_below_period: assert property (@(posedge clk) disable iff (rst)
    (state == F_PUSH) |-> (rem < period_eff))
    else $error("divider remainder not below period");
  a_stamp_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == F_PUSH) |-> (rem <= diff))
    else $error("bucket stamp underflow");
  a_push_only_done: assert property (@(posedge clk) disable iff (rst)
    item_push |-> $past(state == F_DIV || state == F_PUSH))
    else $error("item handed over before divide finished");
`endif

endmodule
`default_nettype wire

[rtl/ohlc_mid_q.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ohlc_mid_q
// Short queue of classified bars between the front and the back.
// ----------------------------------------------------------------------------
module ohlc_mid_q import ohlc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr,
  input  item_t     wr_data,
  output logic      full,
  input  wire logic rd,
  output item_t     rd_data,
  output logic      empty
);

  localparam int PTR_W = (MQ_DEPTH > 1) ? $clog2(MQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(MQ_DEPTH + 1);

  item_t            slots [MQ_DEPTH];
  logic [PTR_W-1:0] wp, rp;
  logic [CNT_W-1:0] cnt;
  logic             do_wr, do_rd;

  assign full    = (cnt == CNT_W'(MQ_DEPTH));
  assign empty   = (cnt == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = slots[rp];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wp] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_wr) begin
        wp <= (wp == PTR_W'(MQ_DEPTH - 1)) ? '0 : wp + PTR_W'(1);
      end
      if (do_rd) begin
        rp <= (rp == PTR_W'(MQ_DEPTH - 1)) ? '0 : rp + PTR_W'(1);
      end
      cnt <= cnt + CNT_W'(do_wr) - CNT_W'(do_rd);
    end
  end

endmodule
`default_nettype wire

[rtl/ohlc_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ohlc_back
// Merges classified bars into the open bucket and queues finished bars.
// ----------------------------------------------------------------------------
module ohlc_back import ohlc_pkg::*; #(
  parameter int VOLUME_BITS = DEF_VOLUME_BITS
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [TIME_W-1:0] period_eff,
  input  wire logic [TIME_W-1:0] start_time,
  input  item_t                  item,
  input  wire logic              item_empty,
  output logic                   item_pop,
  input  wire logic              pop,
  output logic                   empty,
  output result_t                res
);

  localparam int SUM_W = ((VOLUME_BITS > VOL_W) ? VOLUME_BITS : VOL_W) + 1;
  localparam logic [SUM_W-1:0] VMAX = SUM_W'((65'd1 << VOLUME_BITS) - 65'd1);
  localparam int PTR_W = $clog2(OQ_DEPTH);
  localparam int CNT_W = $clog2(OQ_DEPTH + 1);

  logic                   bucket_open;
  logic [TIME_W-1:0]      bucket_index;
  logic                   acc_valid;
  logic [PRICE_W-1:0]     acc_open, acc_high, acc_low, acc_close;
  logic [VOLUME_BITS-1:0] acc_volume;

  logic                   changed;
  logic [OTIME_W-1:0]     change_time;
  logic                   base_valid;
  logic [PRICE_W-1:0]     base_high, base_low;
  logic [VOLUME_BITS-1:0] base_vol;
  logic [SUM_W-1:0]       vol_sum;
  logic                   m_valid;
  logic [PRICE_W-1:0]     m_open, m_high, m_low, m_close;
  logic [VOLUME_BITS-1:0] m_vol;
  result_t                r_change, r_flush;

  result_t                oq [OQ_DEPTH];
  logic [PTR_W-1:0]       wp, rp;
  logic [CNT_W-1:0]       cnt;
  logic                   do_pop;

  // a bar is popped only while the result queue has room for two results
  assign item_pop = !item_empty && (cnt <= CNT_W'(OQ_DEPTH - 2));
  assign empty    = (cnt == '0);
  assign do_pop   = pop && !empty;
  assign res      = oq[rp];

  assign changed    = bucket_open && (item.idx != bucket_index);
  // closing bucket is stamped with the settings in force when it closes
  assign change_time = OTIME_W'(bucket_index) * OTIME_W'(period_eff) + OTIME_W'(start_time);
  assign base_valid = acc_valid && !changed;
  assign base_high  = acc_high;
  assign base_low   = acc_low;
  // an empty accumulator always holds zero volume
  assign base_vol   = changed ? '0 : acc_volume;
  assign vol_sum    = SUM_W'(base_vol) + SUM_W'(item.vol);

  always_comb begin
    m_valid = base_valid;
    m_open  = changed ? '0 : acc_open;
    m_high  = changed ? '0 : acc_high;
    m_low   = changed ? '0 : acc_low;
    m_close = changed ? '0 : acc_close;
    m_vol   = base_vol;
    if (item.valid) begin
      m_valid = 1'b1;
      m_close = item.close_p;
      m_vol   = (vol_sum > VMAX) ? VMAX[VOLUME_BITS-1:0] : vol_sum[VOLUME_BITS-1:0];
      if (!base_valid) begin
        m_open = item.open_p;
        m_high = item.high_p;
        m_low  = item.low_p;
      end else begin
        m_high = (item.high_p > base_high) ? item.high_p : base_high;
        m_low  = (item.low_p < base_low) ? item.low_p : base_low;
      end
    end
  end

  always_comb begin
    r_change.time_v   = change_time;
    r_change.open_p   = acc_open;
    r_change.high_p   = acc_high;
    r_change.low_p    = acc_low;
    r_change.close_p  = acc_close;
    r_change.vol      = OVOL_W'(acc_volume);
    r_change.has_data = acc_valid;
    r_change.last     = !item.eos;
    r_flush.time_v    = item.btime;
    r_flush.open_p    = m_open;
    r_flush.high_p    = m_high;
    r_flush.low_p     = m_low;
    r_flush.close_p   = m_close;
    r_flush.vol       = OVOL_W'(m_vol);
    r_flush.has_data  = m_valid;
    r_flush.last      = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (item_pop) begin
      if (changed) begin
        oq[wp] <= r_change;
      end
      if (item.eos) begin
        oq[wp + PTR_W'(changed)] <= r_flush;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_open  <= 1'b0;
      bucket_index <= '0;
      acc_valid    <= 1'b0;
      acc_open     <= '0;
      acc_high     <= '0;
      acc_low      <= '0;
      acc_close    <= '0;
      acc_volume   <= '0;
      wp           <= '0;
      rp           <= '0;
      cnt          <= '0;
    end else begin
      if (item_pop) begin
        if (item.eos) begin
          bucket_open  <= 1'b0;
          bucket_index <= '0;
          acc_valid    <= 1'b0;
          acc_open     <= '0;
          acc_high     <= '0;
          acc_low      <= '0;
          acc_close    <= '0;
          acc_volume   <= '0;
        end else begin
          bucket_open  <= 1'b1;
          bucket_index <= item.idx;
          acc_valid    <= m_valid;
          acc_open     <= m_open;
          acc_high     <= m_high;
          acc_low      <= m_low;
          acc_close    <= m_close;
          acc_volume   <= m_vol;
        end
        wp <= wp + PTR_W'(changed) + PTR_W'(item.eos);
      end
      if (do_pop) begin
        rp <= rp + PTR_W'(1);
      end
      cnt <= cnt + CNT_W'(item_pop && changed) + CNT_W'(item_pop && item.eos)
             - CNT_W'(do_pop);
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(OQ_DEPTH))
    else $error("result queue overflow");
  a_eos_closes: assert property (@(posedge clk) disable iff (rst)
    (item_pop && item.eos) |=> !bucket_open && !acc_valid)
    else $error("end of series left a bucket open");
  a_quiet_bar: assert property (@(posedge clk) disable iff (rst)
    (item_pop && !changed && !item.eos && !do_pop) |=> (cnt == $past(cnt)))
    else $error("merge produced a result");
  a_empty_acc_zero: assert property (@(posedge clk) disable iff (rst)
    !acc_valid |-> (acc_volume == '0))
    else $error("empty accumulator holds volume");
`endif

endmodule
`default_nettype wire

[rtl/ohlc_bar_resampler.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ohlc_bar_resampler
// Merges a stream of fine price bars into coarser time buckets.
// ----------------------------------------------------------------------------
// Input bars enter on push/full: a beat moves when push is high and full is
// low. Finished bars leave on empty/pop: the oldest one is on the out_* ports
// while empty is low and is taken when pop is high. One input bar gives zero,
// one or two results; run_last marks the final one of a bar.
// The front takes a new bar only once it is done with the last: it captures
// the bar, runs the bit-serial divide that finds the bucket index and hands
// the bar to a two-entry queue, waiting while that queue is full. The back
// merges a bar once its four-deep result queue has two free slots.
// Registers period_seconds (index 0) and start_time (index 1) are written on
// cfg_valid/cfg_ready, which is always ready; write them only while idle.
// A period of zero acts as one.
// Reset (rst, synchronous) empties both queues, drops the open bucket and
// restores period 60 and start 0. When the receiver stalls, results pile up
// in the result queue, then the mid queue, then full holds off new bars.
// ----------------------------------------------------------------------------
module ohlc_bar_resampler import ohlc_pkg::*; #(
  parameter int PRICE_BITS  = DEF_PRICE_BITS,
  parameter int VOLUME_BITS = DEF_VOLUME_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  output logic                      full,
  input  wire logic [TIME_W-1:0]    bar_time,
  input  wire logic [PRICE_W-1:0]   open_price,
  input  wire logic [PRICE_W-1:0]   high_price,
  input  wire logic [PRICE_W-1:0]   low_price,
  input  wire logic [PRICE_W-1:0]   close_price,
  input  wire logic [VOL_W-1:0]     volume,
  input  wire logic                 end_of_series,
  output logic                      empty,
  input  wire logic                 pop,
  output logic [OTIME_W-1:0]        out_time,
  output logic [PRICE_W-1:0]        out_open,
  output logic [PRICE_W-1:0]        out_high,
  output logic [PRICE_W-1:0]        out_low,
  output logic [PRICE_W-1:0]        out_close,
  output logic [OVOL_W-1:0]         out_volume,
  output logic                      out_has_data,
  output logic                      run_last,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [TIME_W-1:0]    cfg_data
);

  logic [TIME_W-1:0] period_seconds;
  logic [TIME_W-1:0] start_time;
  logic [TIME_W-1:0] period_eff;
  logic              f_push, mq_full, mq_empty, mq_pop;
  item_t             f_item, mq_item;
  result_t           res;

  assign cfg_ready  = 1'b1;
  assign period_eff = (period_seconds == '0) ? TIME_W'(1) : period_seconds;

  always_ff @(posedge clk) begin
    if (rst) begin
      period_seconds <= PERIOD_RESET;
      start_time     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      priority if (cfg_index == REG_PERIOD) begin
        period_seconds <= cfg_data;
      end else if (cfg_index == REG_START) begin
        start_time <= cfg_data;
      end
    end
  end

  ohlc_front #(.PRICE_BITS(PRICE_BITS)) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .bar_time      (bar_time),
    .open_price    (open_price),
    .high_price    (high_price),
    .low_price     (low_price),
    .close_price   (close_price),
    .volume        (volume),
    .end_of_series (end_of_series),
    .period_eff    (period_eff),
    .start_time    (start_time),
    .item_push     (f_push),
    .item_full     (mq_full),
    .item          (f_item)
  );

  ohlc_mid_q u_mid_q (
    .clk     (clk),
    .rst     (rst),
    .wr      (f_push),
    .wr_data (f_item),
    .full    (mq_full),
    .rd      (mq_pop),
    .rd_data (mq_item),
    .empty   (mq_empty)
  );

  ohlc_back #(.VOLUME_BITS(VOLUME_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .period_eff (period_eff),
    .start_time (start_time),
    .item       (mq_item),
    .item_empty (mq_empty),
    .item_pop   (mq_pop),
    .pop        (pop),
    .empty      (empty),
    .res        (res)
  );

  assign out_time     = res.time_v;
  assign out_open     = res.open_p;
  assign out_high     = res.high_p;
  assign out_low      = res.low_p;
  assign out_close    = res.close_p;
  assign out_volume   = res.vol;
  assign out_has_data = res.has_data;
  assign run_last     = res.last;

endmodule
`default_nettype wire

[test/tb_ohlc_bar_resampler.sv]
// ----------------------------------------------------------------------------
// tb_ohlc_bar_resampler
// Self-checking bench for the OHLC bar resampler.
// ----------------------------------------------------------------------------
// A short table of hand-picked bars runs first: the reset settings, price and
// volume extremes, bars with a zero price, empty buckets, a zero period and
// times before the origin. Then eight phases of random bar streams, each
// under its own period and origin, walk time forward in small steps with
// jumps, backward steps and broken bars mixed in. A bench-side model folds
// every accepted bar into buckets and queues the bars it expects; each popped
// bar is checked field by field against the oldest one. Both sides idle in
// random bursts, and once the reader stops long enough to back up the block.
// ----------------------------------------------------------------------------
module tb_ohlc_bar_resampler;
  import ohlc_pkg::*;

  localparam int SETTLE_CYCLES = 80;
  localparam int PHASE_BARS    = 180;
  localparam int NUM_PHASES    = 8;
  localparam int HOLD_CYCLES   = 1000;
  localparam int MAX_SHOWN     = 10;
  localparam logic [OVOL_W-1:0] VOL_CAP = {OVOL_W{1'b1}};

  typedef struct packed {
    logic [TIME_W-1:0]  stamp;
    logic [PRICE_W-1:0] open_p;
    logic [PRICE_W-1:0] high_p;
    logic [PRICE_W-1:0] low_p;
    logic [PRICE_W-1:0] close_p;
    logic [VOL_W-1:0]   vol;
    logic               eos;
  } bar_t;

  typedef enum logic {ROW_BAR, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    bar_t                   bar;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [TIME_W-1:0]      reg_val;
    bit                     known;
    result_t                want;
  } row_t;

  logic                 clk;
  logic                 rst           = 1'b1;
  logic                 push          = 1'b0;
  logic                 full;
  logic [TIME_W-1:0]    bar_time      = '0;
  logic [PRICE_W-1:0]   open_price    = '0;
  logic [PRICE_W-1:0]   high_price    = '0;
  logic [PRICE_W-1:0]   low_price     = '0;
  logic [PRICE_W-1:0]   close_price   = '0;
  logic [VOL_W-1:0]     volume        = '0;
  logic                 end_of_series = 1'b0;
  logic                 empty;
  logic                 pop           = 1'b0;
  logic [OTIME_W-1:0]   out_time;
  logic [PRICE_W-1:0]   out_open;
  logic [PRICE_W-1:0]   out_high;
  logic [PRICE_W-1:0]   out_low;
  logic [PRICE_W-1:0]   out_close;
  logic [OVOL_W-1:0]    out_volume;
  logic                 out_has_data;
  logic                 run_last;
  logic                 cfg_valid     = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index     = '0;
  logic [TIME_W-1:0]    cfg_data      = '0;

  ohlc_bar_resampler uut (.*);

  // bench copy of the block settings and bucket state
  logic [TIME_W-1:0]  cfg_period = PERIOD_RESET;
  logic [TIME_W-1:0]  cfg_origin = '0;
  bit                 bkt_live;
  logic [TIME_W-1:0]  bkt_num    = '0;
  bit                 acc_seen;
  logic [PRICE_W-1:0] acc_open   = '0;
  logic [PRICE_W-1:0] acc_high   = '0;
  logic [PRICE_W-1:0] acc_low    = '0;
  logic [PRICE_W-1:0] acc_close  = '0;
  logic [OVOL_W-1:0]  acc_vol    = '0;

  result_t bars_due[$];
  int      errors;
  bit      idling = 1'b1;
  bit      hold_req;
  bit      hold_done;
  int      rx_gap;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic logic [TIME_W-1:0] eff_period();
    return (cfg_period == '0) ? TIME_W'(1) : cfg_period;
  endfunction

  task automatic close_bucket(input logic [TIME_W-1:0] num, input bit last,
                              input bit keep);
    result_t r;
    r.time_v   = OTIME_W'(num) * OTIME_W'(eff_period()) + OTIME_W'(cfg_origin);
    r.open_p   = acc_open;
    r.high_p   = acc_high;
    r.low_p    = acc_low;
    r.close_p  = acc_close;
    r.vol      = acc_vol;
    r.has_data = acc_seen;
    r.last     = last;
    if (keep) bars_due = {bars_due, r};
    acc_seen  = 1'b0;
    acc_open  = '0;
    acc_high  = '0;
    acc_low   = '0;
    acc_close = '0;
    acc_vol   = '0;
  endtask

  task automatic fold_bar(input bar_t b, input bit keep);
    logic [TIME_W-1:0] num;
    bit                good;
    // offset from the origin wraps before the divide
    num  = (b.stamp - cfg_origin) / eff_period();
    good = b.open_p != '0 && b.high_p != '0 && b.low_p != '0 && b.close_p != '0;
    if (bkt_live && num != bkt_num) close_bucket(bkt_num, !b.eos, keep);
    bkt_live = 1'b1;
    bkt_num  = num;
    if (good) begin
      if (!acc_seen) begin
        acc_seen  = 1'b1;
        acc_open  = b.open_p;
        acc_high  = b.high_p;
        acc_low   = b.low_p;
        acc_close = b.close_p;
        acc_vol   = OVOL_W'(b.vol);
      end else begin
        if (b.high_p > acc_high) acc_high = b.high_p;
        if (b.low_p < acc_low) acc_low = b.low_p;
        acc_close = b.close_p;
        acc_vol   = (VOL_CAP - acc_vol < OVOL_W'(b.vol)) ? VOL_CAP
                                                         : acc_vol + OVOL_W'(b.vol);
      end
    end
    if (b.eos) begin
      close_bucket(num, 1'b1, keep);
      bkt_live = 1'b0;
      bkt_num  = '0;
    end
  endtask

  task automatic flag(input string msg);
    errors++;
    if (errors <= MAX_SHOWN) $display("mismatch: %s", msg);
  endtask

  task automatic check_result();
    result_t got;
    result_t want;
    got = {out_time, out_open, out_high, out_low, out_close, out_volume,
           out_has_data, run_last};
    if (bars_due.size() == 0) begin
      flag($sformatf("bar with nothing pending, out_time %0h", got.time_v));
      return;
    end
    want = bars_due.pop_front();
    if (got.time_v !== want.time_v)
      flag($sformatf("out_time expected %0h got %0h", want.time_v, got.time_v));
    if (got.open_p !== want.open_p)
      flag($sformatf("out_open expected %0h got %0h", want.open_p, got.open_p));
    if (got.high_p !== want.high_p)
      flag($sformatf("out_high expected %0h got %0h", want.high_p, got.high_p));
    if (got.low_p !== want.low_p)
      flag($sformatf("out_low expected %0h got %0h", want.low_p, got.low_p));
    if (got.close_p !== want.close_p)
      flag($sformatf("out_close expected %0h got %0h", want.close_p, got.close_p));
    if (got.vol !== want.vol)
      flag($sformatf("out_volume expected %0h got %0h", want.vol, got.vol));
    if (got.has_data !== want.has_data)
      flag($sformatf("out_has_data expected %0b got %0b", want.has_data, got.has_data));
    if (got.last !== want.last)
      flag($sformatf("run_last expected %0b got %0b", want.last, got.last));
  endtask

  // reader side: random stall bursts, plus one long hold to back up the block
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_result();
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        rx_gap    = HOLD_CYCLES - 1;
        pop <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        pop <= 1'b0;
      end else if (idling && $urandom_range(0, 11) == 0) begin
        rx_gap = $urandom_range(0, 15);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // push stays high across back-to-back beats; only an idle burst or a settle lowers it
  task automatic send_bar(input bar_t b, input bit keep);
    if (idling && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    push          <= 1'b1;
    bar_time      <= b.stamp;
    open_price    <= b.open_p;
    high_price    <= b.high_p;
    low_price     <= b.low_p;
    close_price   <= b.close_p;
    volume        <= b.vol;
    end_of_series <= b.eos;
    do @(posedge clk); while (full);
    fold_bar(b, keep);
  endtask

  // more: another write follows at once, so valid stays up
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [TIME_W-1:0] val, input bit more);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (!more) cfg_valid <= 1'b0;
    if (idx == REG_PERIOD) cfg_period = val;
    else if (idx == REG_START) cfg_origin = val;
  endtask

  // drain everything, then wait with push low to clear the pipe
  task automatic settle();
    push <= 1'b0;
    while (bars_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic row_t bar_row(logic [TIME_W-1:0] t, logic [PRICE_W-1:0] op,
                                   logic [PRICE_W-1:0] hi, logic [PRICE_W-1:0] lo,
                                   logic [PRICE_W-1:0] cl, logic [VOL_W-1:0] v,
                                   logic eos);
    row_t r;
    r.kind    = ROW_BAR;
    r.bar     = {t, op, hi, lo, cl, v, eos};
    r.reg_idx = '0;
    r.reg_val = '0;
    r.known   = 1'b0;
    r.want    = '0;
    return r;
  endfunction

  function automatic row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] val);
    row_t r;
    r.kind    = ROW_CFG;
    r.bar     = '0;
    r.reg_idx = idx;
    r.reg_val = val;
    r.known   = 1'b0;
    r.want    = '0;
    return r;
  endfunction

  function automatic row_t known_row(row_t r, result_t w);
    r.known = 1'b1;
    r.want  = w;
    return r;
  endfunction

  initial begin : stimulus
    row_t              plan[$];
    bar_t              b;
    logic [TIME_W-1:0] per;
    logic [TIME_W-1:0] org;
    logic [TIME_W-1:0] t;
    logic [TIME_W-1:0] step_lim;
    int                pick;

    // reset settings: period 60, origin 0
    plan = {plan, known_row(bar_row(0, 100, 120, 90, 110, 5, 1),
      {64'd0, 32'd100, 32'd120, 32'd90, 32'd110, 48'd5, 1'b1, 1'b1})};
    plan = {plan, bar_row(59, 200, 250, 150, 210, 7, 0)};
    plan = {plan, bar_row(30, 205, 300, 100, 220, 32'hFFFF_FFFF, 0)};
    plan = {plan, bar_row(61, 0, 5, 5, 5, 1, 0)};
    plan = {plan, bar_row(90, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          32'hFFFF_FFFF, 32'hFFFF_FFFF, 0)};
    plan = {plan, bar_row(119, 1, 1, 1, 1, 3, 0)};
    // bucket change and end of series on one bar, new bucket left empty
    plan = {plan, bar_row(150, 0, 0, 0, 0, 0, 1)};
    plan = {plan, known_row(bar_row(300, 50, 0, 50, 50, 9, 1),
      {64'd300, 32'd0, 32'd0, 32'd0, 32'd0, 48'd0, 1'b0, 1'b1})};
    plan = {plan, known_row(bar_row(32'hFFFF_FFFF, 1, 1, 1, 1, 0, 1),
      {64'd4294967280, 32'd1, 32'd1, 32'd1, 32'd1, 48'd0, 1'b1, 1'b1})};
    plan = {plan, bar_row(10, 7, 8, 6, 7, 1, 0)};
    plan = {plan, bar_row(20, 9, 0, 9, 9, 4, 0)};
    plan = {plan, bar_row(25, 9, 9, 0, 9, 4, 0)};
    plan = {plan, bar_row(28, 9, 9, 9, 0, 4, 0)};
    plan = {plan, bar_row(70, 1, 2, 3, 4, 5, 1)};
    // zero period acts as one; times below the origin wrap
    plan = {plan, cfg_row(REG_PERIOD, 32'd0)};
    plan = {plan, cfg_row(REG_START, 32'hFFFF_FFFF)};
    plan = {plan, known_row(bar_row(0, 10, 10, 10, 10, 1, 1),
      {64'h1_0000_0000, 32'd10, 32'd10, 32'd10, 32'd10, 48'd1, 1'b1, 1'b1})};
    plan = {plan, known_row(bar_row(32'hFFFF_FFFE, 10, 10, 10, 10, 1, 1),
      {64'h1_FFFF_FFFE, 32'd10, 32'd10, 32'd10, 32'd10, 48'd1, 1'b1, 1'b1})};
    plan = {plan, bar_row(32'hFFFF_FFFF, 3, 4, 2, 3, 2, 0)};
    plan = {plan, bar_row(5, 6, 9, 5, 8, 2, 0)};
    plan = {plan, bar_row(6, 8, 8, 7, 7, 3, 1)};
    plan = {plan, cfg_row(REG_PERIOD, 32'hFFFF_FFFF)};
    plan = {plan, cfg_row(REG_START, 32'd0)};
    plan = {plan, known_row(bar_row(32'hFFFF_FFFF, 2, 2, 2, 2, 32'hFFFF_FFFF, 1),
      {64'h0_FFFF_FFFF, 32'd2, 32'd2, 32'd2, 32'd2, 48'h0_FFFF_FFFF, 1'b1, 1'b1})};
    plan = {plan, bar_row(32'hFFFF_FFFE, 5, 9, 1, 6, 7, 0)};
    plan = {plan, bar_row(0, 4, 4, 4, 4, 1, 1)};
    plan = {plan, cfg_row(REG_PERIOD, 32'd1)};
    plan = {plan, bar_row(5, 3, 3, 3, 3, 1, 0)};
    plan = {plan, bar_row(6, 4, 5, 2, 4, 1, 0)};
    plan = {plan, bar_row(6, 4, 6, 1, 5, 1, 1)};

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        if (i == 0 || plan[i-1].kind == ROW_BAR) settle();
        write_reg(plan[i].reg_idx, plan[i].reg_val,
                  i + 1 < plan.size() && plan[i+1].kind == ROW_CFG);
      end else begin
        send_bar(plan[i].bar, !plan[i].known);
        if (plan[i].known) bars_due = {bars_due, plan[i].want};
      end
    end
    settle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin per = 32'd60; org = '0; end
        1: begin per = 32'd1; org = $urandom; end
        2: begin per = 32'd7; org = $urandom; end
        3: begin per = $urandom_range(2, 5000); org = $urandom; end
        4: begin per = '1; org = $urandom; end
        5: begin per = '0; org = '0; end
        6: begin per = $urandom; org = '1; end
        default: begin per = $urandom_range(2, 200); org = $urandom; end
      endcase
      write_reg(REG_PERIOD, per, 1'b1);
      write_reg(REG_START, org, 1'b0);
      idling <= (p < NUM_PHASES - 1);
      if (p == 3) hold_req <= 1'b1;
      step_lim = (per == '0) ? 32'd2 : (per > 32'h0100_0000) ? per >> 3 : per << 1;
      t = org + $urandom_range(0, 1000);
      for (int n = 0; n < PHASE_BARS; n++) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) t = $urandom;
        else if (pick == 1) t = t - $urandom_range(0, step_lim);
        else t = t + $urandom_range(0, step_lim);
        b.stamp   = t;
        b.open_p  = $urandom;
        b.high_p  = $urandom;
        b.low_p   = $urandom;
        b.close_p = $urandom;
        // broken bars: one price or all of them zero
        if ($urandom_range(0, 9) == 0) begin
          case ($urandom_range(0, 4))
            0: b.open_p = '0;
            1: b.high_p = '0;
            2: b.low_p = '0;
            3: b.close_p = '0;
            default: begin
              b.open_p  = '0;
              b.high_p  = '0;
              b.low_p   = '0;
              b.close_p = '0;
            end
          endcase
        end
        b.vol = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1000);
        // every phase closes its series so the next settings start clean
        b.eos = (n == PHASE_BARS - 1) || ($urandom_range(0, 24) == 0);
        send_bar(b, 1'b1);
      end
      settle();
    end

    if (errors == 0 && bars_due.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
